// ===== rtl/core/qrzz_pkg.sv =====
// Package for the QR codeword zigzag reader: constants, payload words,
// walk token type and the module-map address function.
// No dependencies.
package qrzz_pkg;

  // Symbol geometry
  localparam int MAX_SYMBOL_SIZE = 177;
  localparam int MIN_SYMBOL_SIZE = 21;
  localparam int TIMING_COL      = 6;
  localparam int MAP_DEPTH       = MAX_SYMBOL_SIZE * MAX_SYMBOL_SIZE;
  localparam int ADDR_W          = $clog2(MAP_DEPTH);

  // Map word layout: one dark bit and one function flag per module
  localparam int MAP_W         = 2;
  localparam int MAP_DARK_BIT  = 0;
  localparam int MAP_FUNC_BIT  = 1;

  // Configuration register indexes
  localparam logic CFG_SYMBOL_SIZE = 1'b0;
  localparam logic CFG_WORD_COUNT  = 1'b1;
  localparam int   CFG_DATA_W      = 12;

  // Register reset values
  localparam logic [7:0]  SYMBOL_SIZE_RST = 8'd21;
  localparam logic [11:0] WORD_COUNT_RST  = 12'd26;

  // Command modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_OFF_MAP   = 2'd2;

  // Command word
  typedef struct packed {
    logic       mode;
    logic [7:0] row;
    logic [7:0] col;
    logic       dark;
    logic       is_function;
  } req_word_t;

  // Result word
  typedef struct packed {
    logic [7:0]  codeword;
    logic [11:0] word_index;
    logic        is_last_word;
    logic [1:0]  status;
  } rsp_word_t;

  // One walk position in flight, with the walk state that follows it
  typedef struct packed {
    logic       valid;
    logic       oob;
    logic [7:0] x;
    logic [7:0] y;
    logic       dx;
    logic       dy;
  } walk_tok_t;

  // Module map address: row * MAX_SYMBOL_SIZE + col
  function automatic logic [ADDR_W-1:0] map_addr(input logic [7:0] row,
                                                 input logic [7:0] col);
    logic [ADDR_W:0] prod;
    prod = (ADDR_W+1)'(row) * (ADDR_W+1)'(MAX_SYMBOL_SIZE) + (ADDR_W+1)'(col);
    return prod[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/qrzz_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module qrzz_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/qr_codeword_zigzag_reader.sv =====
// QR codeword zigzag reader top level.
// Depends on qrzz_pkg and qrzz_ram.
//
// A load command (mode 0) writes one module into the map if its row and
// column lie on the map, and rewinds the walk. A fetch command (mode 1)
// walks the two-column zigzag on from the walk state, which a rewind puts at
// the lower right corner, and returns one 8-bit codeword on rsp with a
// one-cycle rsp_valid strobe, or an off-map status if the walk leaves the
// symbol; the receiver cannot stall it. The walker issues one map position
// per cycle into a three-stage read pipeline (position, address multiply,
// registered map read), and the codeword is shifted in one bit per data
// module; function modules on the way are skipped. A fetch after all words
// were read answers in the next cycle with status exhausted. busy is high
// while a fetch walks; writing configuration while busy is not allowed.
module qr_codeword_zigzag_reader (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [11:0]           cfg_data,
  // command
  input  logic                  start,
  output logic                  busy,
  input  qrzz_pkg::req_word_t   req,
  // result
  output logic                  rsp_valid,
  output qrzz_pkg::rsp_word_t   rsp
);

  // Configuration and walk state
  logic [7:0]  symbol_size;
  logic [11:0] word_count;
  logic [7:0]  walk_col;
  logic [7:0]  walk_row;
  logic        col_step_right;
  logic        row_step_down;
  logic [11:0] words_done;

  // Walker position while a fetch runs
  logic signed [9:0] cur_x;
  logic signed [9:0] cur_y;
  logic              cur_dx;
  logic              cur_dy;
  logic              gen_on;

  // Read pipeline
  qrzz_pkg::walk_tok_t tok0;
  qrzz_pkg::walk_tok_t tok1;
  qrzz_pkg::walk_tok_t tok2;
  logic [qrzz_pkg::ADDR_W-1:0] rd_addr;
  logic [qrzz_pkg::MAP_W-1:0]  rd_data;

  // Codeword assembly
  logic [7:0] byte_sr;
  logic [2:0] bit_cnt;

  logic       accept;
  logic [7:0] eff_size;
  logic signed [9:0] size_s;
  logic signed [9:0] nx;
  logic signed [9:0] ny;
  logic              ndx;
  logic              ndy;
  logic              n_oob;
  logic              load_in_map;
  logic              func_bit;
  logic              finish_ok;
  logic              finish_off;
  logic [11:0]       words_done_next;

  assign accept = start && !busy;

  // Clamp the configured size into the legal range
  always_comb begin
    if (symbol_size < 8'(qrzz_pkg::MIN_SYMBOL_SIZE)) begin
      eff_size = 8'(qrzz_pkg::MIN_SYMBOL_SIZE);
    end else if (symbol_size > 8'(qrzz_pkg::MAX_SYMBOL_SIZE)) begin
      eff_size = 8'(qrzz_pkg::MAX_SYMBOL_SIZE);
    end else begin
      eff_size = symbol_size;
    end
  end
  assign size_s = signed'({2'b00, eff_size});

  // One zigzag step from the current walker position
  always_comb begin
    nx  = cur_dx ? cur_x + 10'sd1 : cur_x - 10'sd1;
    ndx = !cur_dx;
    ny  = cur_y;
    ndy = cur_dy;
    if (!ndx) begin
      ny = cur_dy ? cur_y + 10'sd1 : cur_y - 10'sd1;
      if (ny < 10'sd0 || ny >= size_s) begin
        ny  = (ny < 10'sd0) ? 10'sd0 : size_s - 10'sd1;
        ndy = !cur_dy;
        nx  = nx - 10'sd2;
        if (nx == 10'(qrzz_pkg::TIMING_COL)) begin
          nx = nx - 10'sd1;
        end
      end
    end
    n_oob = (nx < 10'sd0) || (nx >= size_s) || (ny < 10'sd0) || (ny >= size_s);
  end

  // Module map
  assign load_in_map = (req.row < 8'(qrzz_pkg::MAX_SYMBOL_SIZE)) &&
                       (req.col < 8'(qrzz_pkg::MAX_SYMBOL_SIZE));

  qrzz_ram #(
    .WIDTH (qrzz_pkg::MAP_W),
    .DEPTH (qrzz_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (accept && (req.mode == qrzz_pkg::MODE_LOAD) && load_in_map),
    .waddr (qrzz_pkg::map_addr(req.row, req.col)),
    .wdata ({req.is_function, req.dark}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Evaluate the module that comes back from the map
  assign func_bit   = rd_data[qrzz_pkg::MAP_FUNC_BIT];
  assign finish_off = busy && tok2.valid && tok2.oob;
  assign finish_ok  = busy && tok2.valid && !tok2.oob && !func_bit && (bit_cnt == 3'd7);
  assign words_done_next = words_done + 12'd1;

  // Walker and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_on     <= 1'b0;
      tok0.valid <= 1'b0;
      tok1.valid <= 1'b0;
      tok2.valid <= 1'b0;
    end else if (finish_ok || finish_off) begin
      gen_on     <= 1'b0;
      tok0.valid <= 1'b0;
      tok1.valid <= 1'b0;
      tok2.valid <= 1'b0;
    end else begin
      if (accept && (req.mode == qrzz_pkg::MODE_FETCH) && (words_done < word_count)) begin
        gen_on <= 1'b1;
      end else if (gen_on && n_oob) begin
        gen_on <= 1'b0;
      end
      tok0.valid <= gen_on;
      tok1.valid <= tok0.valid;
      tok2.valid <= tok1.valid;
    end
  end

  always_ff @(posedge clk) begin
    // walker position loads from the walk state at fetch start
    if (accept) begin
      cur_x  <= signed'({2'b00, walk_col});
      cur_y  <= signed'({2'b00, walk_row});
      cur_dx <= col_step_right;
      cur_dy <= row_step_down;
    end else if (gen_on) begin
      cur_x  <= nx;
      cur_y  <= ny;
      cur_dx <= ndx;
      cur_dy <= ndy;
    end
    // position stage
    tok0.oob <= n_oob;
    tok0.x   <= nx[7:0];
    tok0.y   <= ny[7:0];
    tok0.dx  <= ndx;
    tok0.dy  <= ndy;
    // address stage
    tok1.oob <= tok0.oob;
    tok1.x   <= tok0.x;
    tok1.y   <= tok0.y;
    tok1.dx  <= tok0.dx;
    tok1.dy  <= tok0.dy;
    rd_addr  <= qrzz_pkg::map_addr(tok0.y, tok0.x);
    // read stage, aligned with rd_data
    tok2.oob <= tok1.oob;
    tok2.x   <= tok1.x;
    tok2.y   <= tok1.y;
    tok2.dx  <= tok1.dx;
    tok2.dy  <= tok1.dy;
  end

  // Codeword shift register, one data module per cycle; function modules are not shifted in
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= 3'd0;
    end else if (accept) begin
      bit_cnt <= 3'd0;
    end else if (busy && tok2.valid && !tok2.oob && !func_bit) begin
      bit_cnt <= bit_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && tok2.valid && !tok2.oob && !func_bit) begin
      byte_sr <= {byte_sr[6:0], rd_data[qrzz_pkg::MAP_DARK_BIT]};
    end
  end

  // Configuration, walk state, busy and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_size    <= qrzz_pkg::SYMBOL_SIZE_RST;
      word_count     <= qrzz_pkg::WORD_COUNT_RST;
      walk_col       <= qrzz_pkg::SYMBOL_SIZE_RST;
      walk_row       <= qrzz_pkg::SYMBOL_SIZE_RST - 8'd1;
      col_step_right <= 1'b1;
      row_step_down  <= 1'b1;
      words_done     <= 12'd0;
      busy           <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          qrzz_pkg::CFG_SYMBOL_SIZE: symbol_size <= cfg_data[7:0];
          qrzz_pkg::CFG_WORD_COUNT:  word_count  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (req.mode == qrzz_pkg::MODE_LOAD) begin
          // rewind the walk to the lower right corner
          walk_col       <= eff_size;
          walk_row       <= eff_size - 8'd1;
          col_step_right <= 1'b1;
          row_step_down  <= 1'b1;
          words_done     <= 12'd0;
        end else if (words_done >= word_count) begin
          rsp_valid <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end
      if (finish_ok) begin
        busy           <= 1'b0;
        rsp_valid      <= 1'b1;
        walk_col       <= tok2.x;
        walk_row       <= tok2.y;
        col_step_right <= tok2.dx;
        row_step_down  <= tok2.dy;
        words_done     <= words_done_next;
      end else if (finish_off) begin
        busy      <= 1'b0;
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.mode == qrzz_pkg::MODE_FETCH)) begin
      rsp.codeword     <= 8'd0;
      rsp.word_index   <= words_done;
      rsp.is_last_word <= 1'b0;
      rsp.status       <= qrzz_pkg::STATUS_EXHAUSTED;
    end else if (finish_ok) begin
      rsp.codeword     <= {byte_sr[6:0], rd_data[qrzz_pkg::MAP_DARK_BIT]};
      rsp.is_last_word <= (words_done_next == word_count);
      rsp.status       <= qrzz_pkg::STATUS_OK;
    end else if (finish_off) begin
      rsp.codeword     <= 8'd0;
      rsp.is_last_word <= 1'b0;
      rsp.status       <= qrzz_pkg::STATUS_OFF_MAP;
    end
  end

endmodule

// ===== bench/qr_codeword_zigzag_reader_test.sv =====
// Self-checking bench for qr_codeword_zigzag_reader: loads the smallest symbol,
// fetches codewords under random start gaps and checks every result word.
// Depends on qrzz_pkg and the reader RTL.
module qr_codeword_zigzag_reader_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;  // a fetch here walks at most a few hundred modules
  localparam int SETTLE      = 8;
  localparam int BASE_SIZE   = 21;
  localparam int ITEM_TARGET = 560;
  localparam int REQ_W       = $bits(qrzz_pkg::req_word_t);

  // Zigzag walk predictor and queue of codewords still owed by the block
  class codeword_scoreboard;
    bit                  dark_bits [qrzz_pkg::MAP_DEPTH];
    bit                  func_bits [qrzz_pkg::MAP_DEPTH];
    bit                  loaded [qrzz_pkg::MAP_DEPTH];
    logic [7:0]          size_reg;
    logic [11:0]         count_reg;
    int                  walk_x;
    int                  walk_y;
    bit                  step_right;
    bit                  step_down;
    logic [11:0]         words_done;
    qrzz_pkg::rsp_word_t codewords_due [$];
    int                  errors;

    function void power_up();
      size_reg  = qrzz_pkg::SYMBOL_SIZE_RST;
      count_reg = qrzz_pkg::WORD_COUNT_RST;
      errors    = 0;
      rewind();
    endfunction

    // Out-of-range sizes clamp to the legal span
    function int live_size();
      if (size_reg < qrzz_pkg::MIN_SYMBOL_SIZE) return qrzz_pkg::MIN_SYMBOL_SIZE;
      if (size_reg > qrzz_pkg::MAX_SYMBOL_SIZE) return qrzz_pkg::MAX_SYMBOL_SIZE;
      return int'(size_reg);
    endfunction

    function void rewind();
      walk_x     = live_size();
      walk_y     = live_size() - 1;
      step_right = 1'b1;
      step_down  = 1'b1;
      words_done = '0;
    endfunction

    function void write_reg(logic idx, logic [11:0] data);
      if (idx == qrzz_pkg::CFG_SYMBOL_SIZE) size_reg = data[7:0];
      else count_reg = data;
    endfunction

    function int pending();
      return codewords_due.size();
    endfunction

    // Walk one codeword from the current walk state without committing it;
    // clean drops when the walk would read a module never loaded
    function void walk_word(output qrzz_pkg::rsp_word_t due, output int end_x,
                            output int end_y, output bit end_right,
                            output bit end_down, output bit clean);
      int         s;
      int         x;
      int         y;
      int         dx;
      int         dy;
      int         a;
      logic [7:0] bits;
      bit         off;
      bit         found;
      due            = '0;
      due.word_index = words_done;
      clean          = 1'b1;
      end_x          = walk_x;
      end_y          = walk_y;
      end_right      = step_right;
      end_down       = step_down;
      if (words_done >= count_reg) begin
        due.status = qrzz_pkg::STATUS_EXHAUSTED;
        return;
      end
      s     = live_size();
      x     = walk_x;
      y     = walk_y;
      dx    = step_right ? 1 : -1;
      dy    = step_down ? 1 : -1;
      a     = 0;
      bits  = '0;
      off   = 1'b0;
      found = 1'b0;
      for (int j = 0; j < 8 && !off && clean; j++) begin
        found = 1'b0;
        while (!found && !off && clean) begin
          // alternate right/left; a right step also advances the row
          x  = x + dx;
          dx = -dx;
          if (dx < 0) begin
            y = y + dy;
            if (y < 0 || y >= s) begin
              y  = (y < 0) ? 0 : s - 1;
              dy = -dy;
              x  = x - 2;
              if (x == qrzz_pkg::TIMING_COL) x = x - 1;
            end
          end
          if (x < 0 || x >= s || y < 0 || y >= s) begin
            off = 1'b1;
          end else begin
            a = y * qrzz_pkg::MAX_SYMBOL_SIZE + x;
            if (!loaded[a]) clean = 1'b0;
            else if (!func_bits[a]) found = 1'b1;
          end
        end
        if (found && dark_bits[a]) bits[7 - j] = 1'b1;
      end
      if (off) begin
        // walk and word counter keep their old values
        due.status = qrzz_pkg::STATUS_OFF_MAP;
      end else if (clean) begin
        end_x            = x;
        end_y            = y;
        end_right        = (dx > 0);
        end_down         = (dy > 0);
        due.codeword     = bits;
        due.is_last_word = ((words_done + 12'd1) == count_reg);
        due.status       = qrzz_pkg::STATUS_OK;
      end
    endfunction

    // True when the next fetch reads only loaded modules
    function bit fetch_safe();
      qrzz_pkg::rsp_word_t due;
      int                  nx;
      int                  ny;
      bit                  nright;
      bit                  ndown;
      bit                  clean;
      walk_word(due, nx, ny, nright, ndown, clean);
      return clean;
    endfunction

    // Apply one accepted command word; a fetch queues the codeword it must return
    function void note_command(qrzz_pkg::req_word_t w);
      int                  a;
      int                  nx;
      int                  ny;
      bit                  nright;
      bit                  ndown;
      bit                  clean;
      qrzz_pkg::rsp_word_t due;
      if (w.mode == qrzz_pkg::MODE_LOAD) begin
        // rows or columns past the map write nothing but still rewind
        if (w.row < qrzz_pkg::MAX_SYMBOL_SIZE && w.col < qrzz_pkg::MAX_SYMBOL_SIZE) begin
          a            = int'(w.row) * qrzz_pkg::MAX_SYMBOL_SIZE + int'(w.col);
          dark_bits[a] = w.dark;
          func_bits[a] = w.is_function;
          loaded[a]    = 1'b1;
        end
        rewind();
        return;
      end
      walk_word(due, nx, ny, nright, ndown, clean);
      if (due.status == qrzz_pkg::STATUS_OK) begin
        walk_x     = nx;
        walk_y     = ny;
        step_right = nright;
        step_down  = ndown;
        words_done = words_done + 12'd1;
      end
      codewords_due.push_back(due);
    endfunction

    function void compare(string field, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    // Match one result word against the oldest owed codeword
    function void check_word(qrzz_pkg::rsp_word_t got);
      qrzz_pkg::rsp_word_t want;
      if (codewords_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        return;
      end
      want = codewords_due.pop_front();
      compare("codeword", 12'(want.codeword), 12'(got.codeword));
      compare("word_index", want.word_index, got.word_index);
      compare("is_last_word", 12'(want.is_last_word), 12'(got.is_last_word));
      compare("status", 12'(want.status), 12'(got.status));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [11:0]         cfg_data;
  logic                start;
  logic                busy;
  qrzz_pkg::req_word_t req;
  logic                rsp_valid;
  qrzz_pkg::rsp_word_t rsp;

  codeword_scoreboard  sb;
  codeword_scoreboard  shadow;
  qrzz_pkg::req_word_t plan [$];
  int quiet_cycles;
  int burst_left;
  int words_sent;

  qr_codeword_zigzag_reader DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Monitor: track accepted words, results and register writes; watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) sb.note_command(req);
      if (rsp_valid) sb.check_word(rsp);
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if ((start && !busy) || rsp_valid || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("qr_codeword_zigzag_reader verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic qrzz_pkg::req_word_t load_word(int row, int col, bit dark, bit is_func);
    qrzz_pkg::req_word_t w;
    w.mode        = qrzz_pkg::MODE_LOAD;
    w.row         = 8'(row);
    w.col         = 8'(col);
    w.dark        = dark;
    w.is_function = is_func;
    return w;
  endfunction

  // Fetch ignores the other fields, so they carry noise
  function automatic qrzz_pkg::req_word_t fetch_word();
    qrzz_pkg::req_word_t w;
    w      = qrzz_pkg::req_word_t'(REQ_W'($urandom));
    w.mode = qrzz_pkg::MODE_FETCH;
    return w;
  endfunction

  // Rewinding load somewhere inside the preloaded symbol
  function automatic qrzz_pkg::req_word_t base_load();
    return load_word($urandom_range(0, BASE_SIZE - 1), $urandom_range(0, BASE_SIZE - 1),
                     1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0));
  endfunction

  // Plans run on a copy of the scoreboard, taken while nothing is in flight
  function automatic void plan_begin();
    plan.delete();
    shadow = new sb;
  endfunction

  function automatic void plan_load(qrzz_pkg::req_word_t w);
    shadow.note_command(w);
    plan.push_back(w);
  endfunction

  // A fetch that would read a module never loaded becomes a rewinding load
  function automatic void plan_fetch();
    if (shadow.fetch_safe()) plan_load(fetch_word());
    else plan_load(base_load());
  endfunction

  // Present one word and hold it until accepted; bursts with random gaps
  task automatic send_word(input qrzz_pkg::req_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    words_sent++;
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_plan();
    while (plan.size() != 0) send_word(plan.pop_front());
  endtask

  // Stop sending and wait until every owed codeword has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register writes while idle; noise in the unused data bits of the size write
  task automatic write_config(input bit do_size, input logic [7:0] size,
                              input bit do_count, input logic [11:0] count);
    if (do_size) begin
      cfg_we    <= 1'b1;
      cfg_index <= qrzz_pkg::CFG_SYMBOL_SIZE;
      cfg_data  <= {4'($urandom_range(0, 15)), size};
      @(posedge clk);
    end
    if (do_count) begin
      cfg_we    <= 1'b1;
      cfg_index <= qrzz_pkg::CFG_WORD_COUNT;
      cfg_data  <= count;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          span;
    bit          wide;
    logic [7:0]  size;
    logic [11:0] count;
    sb = new();
    sb.power_up();
    burst_left = 0;
    words_sent = 0;
    rst        <= 1'b1;
    start      <= 1'b0;
    req        <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= qrzz_pkg::CFG_SYMBOL_SIZE;
    cfg_data   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Preload every module of the smallest symbol
    for (int r = 0; r < BASE_SIZE; r++) begin
      for (int c = 0; c < BASE_SIZE; c++) begin
        send_word(load_word(r, c, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0));
      end
    end
    drain();

    // Directed: reset registers, map corners, loads off the map
    plan_begin();
    repeat (3) plan_fetch();
    plan_load(load_word(0, 0, 1'b1, 1'b0));
    plan_load(load_word(176, 176, 1'b1, 1'b0));
    plan_load(load_word(255, 255, 1'b1, 1'b1));
    plan_load(load_word(177, 0, 1'b0, 1'b1));
    plan_load(load_word(0, 177, 1'b1, 1'b1));
    plan_load(load_word(20, 20, 1'b1, 1'b1));
    repeat (2) plan_fetch();
    send_plan();
    drain();
    // size below range acts as the smallest symbol, single word then exhausted
    write_config(1'b1, 8'd0, 1'b1, 12'd1);
    plan_begin();
    plan_load(load_word(20, 20, 1'b0, 1'b0));
    repeat (3) plan_fetch();
    send_plan();
    drain();
    // size above range acts as the largest symbol; load the first strip's foot
    write_config(1'b1, 8'd255, 1'b1, 12'd2);
    plan_begin();
    for (int r = 169; r < 177; r++) begin
      for (int c = 175; c < 177; c++) begin
        plan_load(load_word(r, c, 1'($urandom_range(0, 1)), 1'b0));
      end
    end
    repeat (3) plan_fetch();
    send_plan();
    drain();
    // shrink the symbol under a walk in progress, the walk leaves the symbol
    write_config(1'b1, 8'd21, 1'b1, 12'd4095);
    plan_begin();
    repeat (2) plan_fetch();
    send_plan();
    drain();
    write_config(1'b0, 8'd0, 1'b1, 12'd0);
    plan_begin();
    plan_fetch();
    send_plan();
    drain();
    // long walk on the smallest symbol, runs off the left edge
    write_config(1'b1, 8'($urandom_range(0, BASE_SIZE)), 1'b1,
                 ($urandom_range(0, 1) == 0) ? 12'd4095 : 12'd3706);
    plan_begin();
    plan_load(base_load());
    repeat (60) plan_fetch();
    send_plan();
    drain();

    // Random phases: register settings, rewinds and runs of fetches
    while (words_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       size = 8'($urandom_range(0, 20));
        1:       size = 8'($urandom_range(177, 255));
        default: size = 8'(BASE_SIZE);
      endcase
      case ($urandom_range(0, 9))
        0:       count = 12'd0;
        1:       count = 12'd4095;
        2:       count = 12'd3706;
        default: count = 12'($urandom_range(1, 40));
      endcase
      write_config($urandom_range(0, 3) != 0, size, $urandom_range(0, 2) != 0, count);
      plan_begin();
      // without a rewind the walk carries on under the new size
      if ($urandom_range(0, 3) != 0) plan_load(base_load());
      span = $urandom_range(4, 12);
      repeat (span) begin
        if ($urandom_range(0, 19) < 17) begin
          plan_fetch();
        end else begin
          wide = ($urandom_range(0, 4) == 0);
          plan_load(load_word(wide ? $urandom_range(0, 255) : $urandom_range(0, 176),
                              wide ? $urandom_range(0, 255) : $urandom_range(0, 176),
                              1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0));
        end
      end
      send_plan();
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("qr_codeword_zigzag_reader verification clean");
    end else begin
      $display("qr_codeword_zigzag_reader verification failed");
    end
    $finish;
  end

endmodule

// ===== qr_codeword_zigzag_reader.f =====
rtl/core/qrzz_pkg.sv
rtl/core/qrzz_ram.sv
rtl/core/qr_codeword_zigzag_reader.sv
bench/qr_codeword_zigzag_reader_test.sv
